// ----- hdl/ambm_pkg.sv -----
// Shared constants, types and coefficient tables for the piecewise magnitude block.
package ambm_pkg;

    localparam int SEG_COUNT = 9;
    localparam int COEF_W    = 9;
    localparam int LIMIT_W   = 8;
    localparam int FRAC_W    = 8;
    localparam int MAG_W     = 24;

    typedef logic [3:0]        seg_t;
    typedef logic [COEF_W-1:0] coef_t;

    // Ascending ratio thresholds in 1/256 units.
    localparam logic [LIMIT_W-1:0] SEG_LIMIT [0:SEG_COUNT-2] =
        '{8'd25, 8'd51, 8'd78, 8'd106, 8'd137, 8'd171, 8'd200, 8'd210};

    function automatic coef_t alpha_of(input seg_t seg);
        coef_t c;
        case (seg)
            4'd0:    c = 9'd307;
            4'd1:    c = 9'd254;
            4'd2:    c = 9'd250;
            4'd3:    c = 9'd243;
            4'd4:    c = 9'd234;
            4'd5:    c = 9'd223;
            4'd6:    c = 9'd209;
            4'd7:    c = 9'd209;
            4'd8:    c = 9'd181;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic coef_t beta_of(input seg_t seg);
        coef_t c;
        case (seg)
            4'd0:    c = 9'd6;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd56;
            4'd3:    c = 9'd80;
            4'd4:    c = 9'd104;
            4'd5:    c = 9'd126;
            4'd6:    c = 9'd147;
            4'd7:    c = 9'd147;
            4'd8:    c = 9'd180;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/piecewise_ambm_magnitude.sv -----
// Top level of the piecewise alpha-max-beta-min magnitude pipeline.
//
// A sample (real_part, imag_part) is taken at every rising edge where start
// is high and busy is low. busy is held low: the pipeline takes one beat per
// clock, so the sustained rate is one sample per cycle.
// Each result appears on magnitude for exactly one cycle with done high,
// once its sample has passed through all four register stages. Results
// leave in the order samples came in. The four register stages are:
// absolute value and sort, segment compare against the eight ratio limits,
// the two coefficient multiplies, and the final add into the output
// register. magnitude carries eight fraction bits and holds the low 24
// bits of the sum. Reset clears every valid bit, so no result is produced
// for samples in flight. The receiver cannot stall; every result must be
// taken when shown.
module piecewise_ambm_magnitude #(
    parameter int IN_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [IN_WIDTH-1:0]  real_part,
    input  logic signed [IN_WIDTH-1:0]  imag_part,
    output logic                        done,
    output logic [ambm_pkg::MAG_W-1:0]  magnitude
);
    import ambm_pkg::*;

    logic                accept;
    logic                s1_valid;
    logic [IN_WIDTH-1:0] s1_big;
    logic [IN_WIDTH-1:0] s1_little;
    logic                s2_valid;
    logic [IN_WIDTH-1:0] s2_big;
    logic [IN_WIDTH-1:0] s2_little;
    seg_t                s2_seg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    ambm_sort #(.IN_WIDTH(IN_WIDTH)) u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .real_part (real_part),
        .imag_part (imag_part),
        .valid_out (s1_valid),
        .big       (s1_big),
        .little    (s1_little)
    );

    ambm_seg #(.IN_WIDTH(IN_WIDTH)) u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (s1_valid),
        .big_in     (s1_big),
        .little_in  (s1_little),
        .valid_out  (s2_valid),
        .big_out    (s2_big),
        .little_out (s2_little),
        .seg        (s2_seg)
    );

    ambm_mac #(.IN_WIDTH(IN_WIDTH)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .big_in    (s2_big),
        .little_in (s2_little),
        .seg       (s2_seg),
        .valid_out (done),
        .magnitude (magnitude)
    );

    // A sample taken with reset held off throughout produces a result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(accept, 4) && $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2)
         && $past(rst_n, 1)) |-> done)
        else $error("accepted sample produced no result");

    // No result without an earlier accepted sample.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result without an accepted sample");

    // A zero sample gives a zero magnitude.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(real_part, 4) == '0 && $past(imag_part, 4) == '0)
        |-> magnitude == '0)
        else $error("zero sample gave nonzero magnitude");

endmodule

// ----- hdl/ambm_sort.sv -----
// First stage: absolute values of both parts, sorted into larger and smaller.
module ambm_sort #(
    parameter int IN_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    input  logic signed [IN_WIDTH-1:0] real_part,
    input  logic signed [IN_WIDTH-1:0] imag_part,
    output logic                       valid_out,
    output logic        [IN_WIDTH-1:0] big,
    output logic        [IN_WIDTH-1:0] little
);
    import ambm_pkg::*;

    logic [IN_WIDTH-1:0] abs_re;
    logic [IN_WIDTH-1:0] abs_im;
    logic [IN_WIDTH-1:0] big_next;
    logic [IN_WIDTH-1:0] little_next;
    logic [IN_WIDTH-1:0] big_reg;
    logic [IN_WIDTH-1:0] little_reg;
    logic                valid_reg;

    // Unsigned result keeps the magnitude of the most negative value exactly.
    assign abs_re = real_part[IN_WIDTH-1] ? (~real_part + 1'b1) : real_part;
    assign abs_im = imag_part[IN_WIDTH-1] ? (~imag_part + 1'b1) : imag_part;

    always_comb
    begin
        if (abs_re < abs_im)
        begin
            big_next    = abs_im;
            little_next = abs_re;
        end
        else
        begin
            big_next    = abs_re;
            little_next = abs_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        big_reg    <= big_next;
        little_reg <= little_next;
    end

    assign valid_out = valid_reg;
    assign big       = big_reg;
    assign little    = little_reg;

endmodule

// ----- hdl/ambm_seg.sv -----
// Second stage: segment selection by comparing little*256 against limit*big.
module ambm_seg #(
    parameter int IN_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  logic [IN_WIDTH-1:0] big_in,
    input  logic [IN_WIDTH-1:0] little_in,
    output logic                valid_out,
    output logic [IN_WIDTH-1:0] big_out,
    output logic [IN_WIDTH-1:0] little_out,
    output ambm_pkg::seg_t      seg
);
    import ambm_pkg::*;

    localparam int CMP_W = IN_WIDTH + FRAC_W;

    logic [SEG_COUNT-2:0] below;
    logic [CMP_W-1:0]     scaled_little;
    seg_t                 seg_next;
    seg_t                 seg_reg;
    logic [IN_WIDTH-1:0]  big_reg;
    logic [IN_WIDTH-1:0]  little_reg;
    logic                 valid_reg;

    assign scaled_little = {little_in, {FRAC_W{1'b0}}};

    // floor(little*256/big) < limit is the same as little*256 < limit*big,
    // so no divider is needed. Limits stay below 256, so the product fits.
    always_comb
    begin
        for (int k = 0; k < SEG_COUNT - 1; k++)
        begin
            below[k] = scaled_little < (CMP_W'(SEG_LIMIT[k]) * CMP_W'(big_in));
        end
    end

    always_comb
    begin
        seg_next = seg_t'(SEG_COUNT - 1);
        for (int k = SEG_COUNT - 2; k >= 0; k--)
        begin
            if (below[k])
                seg_next = seg_t'(k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        seg_reg    <= seg_next;
        big_reg    <= big_in;
        little_reg <= little_in;
    end

    assign valid_out  = valid_reg;
    assign big_out    = big_reg;
    assign little_out = little_reg;
    assign seg        = seg_reg;

    // The selected segment is always one of the nine in the table.
    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (seg_reg <= seg_t'(SEG_COUNT - 1)))
        else $error("segment index out of range");

    // Thresholds ascend, so the compare results form a thermometer code.
    a_below_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in |-> ((below & (below - 1'b1)) == below - 1'b1 || below == '0
                      || (below & (below << 1)) == (below << 1)))
        else $error("threshold compares are not monotone");

endmodule

// ----- hdl/ambm_mac.sv -----
// Third and fourth stages: coefficient products, then the sum into the output register.
module ambm_mac #(
    parameter int IN_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic [IN_WIDTH-1:0]       big_in,
    input  logic [IN_WIDTH-1:0]       little_in,
    input  ambm_pkg::seg_t            seg,
    output logic                      valid_out,
    output logic [ambm_pkg::MAG_W-1:0] magnitude
);
    import ambm_pkg::*;

    localparam int PROD_W = IN_WIDTH + COEF_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] prod_a_next;
    logic [PROD_W-1:0] prod_b_next;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic              prod_valid_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [MAG_W-1:0]  mag_reg;
    logic              mag_valid_reg;

    assign prod_a_next = PROD_W'(alpha_of(seg)) * PROD_W'(big_in);
    assign prod_b_next = PROD_W'(beta_of(seg)) * PROD_W'(little_in);
    assign sum_next    = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            mag_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= valid_in;
            mag_valid_reg  <= prod_valid_reg;
        end
    end

    // Wide configurations keep only the low bits of the sum.
    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        mag_reg    <= MAG_W'(sum_next);
    end

    assign valid_out = mag_valid_reg;
    assign magnitude = mag_reg;

endmodule

// ----- dv/tb_piecewise_ambm_magnitude.sv -----
// Self-checking testbench for the piecewise alpha-max-beta-min magnitude block.
`timescale 1ns / 1ps

module tb_piecewise_ambm_magnitude;

    import ambm_pkg::MAG_W;

    localparam int IN_W        = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;
    localparam int REPORT_MAX  = 10;

    localparam int unsigned RATIO_EDGE [8] = '{25, 51, 78, 106, 137, 171, 200, 210};
    localparam int unsigned MAX_WEIGHT [9] = '{307, 254, 250, 243, 234, 223, 209, 209, 181};
    localparam int unsigned MIN_WEIGHT [9] = '{6, 31, 56, 80, 104, 126, 147, 147, 180};

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [IN_W-1:0] real_part;
    logic signed [IN_W-1:0] imag_part;
    logic                   done;
    logic [MAG_W-1:0]       magnitude;

    logic [MAG_W-1:0] pending_mags[$];
    int               error_count = 0;
    int               cycle_count = 0;
    bit               back_to_back;

    piecewise_ambm_magnitude #(
        .IN_WIDTH(IN_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .real_part (real_part),
        .imag_part (imag_part),
        .done      (done),
        .magnitude (magnitude)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [MAG_W-1:0] predict_magnitude(
        input logic signed [IN_W-1:0] re,
        input logic signed [IN_W-1:0] im
    );
        longint      abs_re;
        longint      abs_im;
        longint      hi;
        longint      lo;
        longint      ratio;
        longint      total;
        int          seg;
        abs_re = re;
        abs_im = im;
        if (abs_re < 0)
            abs_re = -abs_re;
        if (abs_im < 0)
            abs_im = -abs_im;
        hi = (abs_re < abs_im) ? abs_im : abs_re;
        lo = (abs_re < abs_im) ? abs_re : abs_im;
        if (hi == 0)
            return '0;
        ratio = (lo * 256) / hi;
        seg = 8;
        for (int k = 7; k >= 0; k--)
        begin
            if (ratio < RATIO_EDGE[k])
                seg = k;
        end
        total = MAX_WEIGHT[seg] * hi + MIN_WEIGHT[seg] * lo;
        return total[MAG_W-1:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Turns one magnitude into a signed value with a random sign.
    // A magnitude of 2^(IN_W-1) only exists as the most negative value.
    function automatic logic signed [IN_W-1:0] signed_of(input int unsigned mag);
        if (mag >= (1 << (IN_W - 1)))
            return {1'b1, {(IN_W-1){1'b0}}};
        if ($urandom_range(0, 1))
            return -$signed(mag[IN_W-1:0]);
        return mag[IN_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_sample(input logic signed [IN_W-1:0] re,
                               input logic signed [IN_W-1:0] im);
        int gap;
        gap = back_to_back ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        real_part <= re;
        imag_part <= im;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_mags.push_back(predict_magnitude(re, im));
        @(negedge clk);
    endtask

    task automatic send_pair(input int unsigned hi, input int unsigned lo);
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        a = signed_of(hi);
        b = signed_of(lo);
        if ($urandom_range(0, 1))
            send_sample(a, b);
        else
            send_sample(b, a);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_mags.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result: magnitude=%0d", magnitude);
            end
            else
            begin
                logic [MAG_W-1:0] want;
                want = pending_mags.pop_front();
                if (magnitude !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("magnitude mismatch: expected %0d, got %0d",
                                 want, magnitude);
                end
            end
        end
    end

    task automatic test_corners();
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd0, -16'sd32768);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, -16'sd1);
        send_sample(-16'sd100, 16'sd100);
    endtask

    // Each threshold is hit from just below and exactly on it.
    task automatic test_segment_edges();
        for (int k = 0; k < 8; k++)
        begin
            send_sample(16'sd256, IN_W'(RATIO_EDGE[k] - 1));
            send_sample(-16'sd256, IN_W'(RATIO_EDGE[k]));
        end
    endtask

    task automatic test_random_samples(input int count);
        int unsigned hi;
        int unsigned lo;
        int          mode;
        int          target;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                back_to_back = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            if (mode < 4)
            begin
                send_sample(IN_W'($urandom), IN_W'($urandom));
            end
            else if (mode < 7)
            begin
                // Ratio is aimed within one step of a segment boundary.
                hi = $urandom_range(1, 1 << (IN_W - 1));
                target = RATIO_EDGE[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
                lo = (target * hi + $urandom_range(0, 255)) / 256;
                if (lo > hi)
                    lo = hi;
                send_pair(hi, lo);
            end
            else if (mode < 9)
            begin
                hi = $urandom_range(0, 300);
                lo = $urandom_range(0, hi);
                send_pair(hi, lo);
            end
            else
            begin
                hi = $urandom_range((1 << (IN_W - 1)) - 4, 1 << (IN_W - 1));
                lo = $urandom_range(0, 1) ? hi : $urandom_range(0, hi);
                send_pair(hi, lo);
            end
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_drain_pause();
        start <= 1'b0;
        while (pending_mags.size() != 0)
            @(posedge clk);
        @(negedge clk);
        test_random_samples(20);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        real_part    = '0;
        imag_part    = '0;
        back_to_back = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corners();
        test_segment_edges();
        test_random_samples(1000);
        test_drain_pause();
        test_random_samples(930);

        start <= 1'b0;
        while (pending_mags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && pending_mags.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
